@@ rtl/core/mclp_pkg.sv @@
// Shared types, character codes and number-parse helpers for the motor command line parser.
// No dependencies.

package mclp_pkg;

    localparam int LINE_CAPACITY_DEF = 64;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Y     = 8'h59;

    localparam logic [16:0] MAG_LIMIT = 17'd32768;

    typedef enum logic [1:0] {
        ACT_DRIVE  = 2'd0,
        ACT_BRAKE  = 2'd1,
        ACT_WHEELS = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [16:0] value;
        logic        negative;
    } num_t;

    localparam num_t NUM_CLEAR = '{phase: PH_SKIP, value: 17'd0, negative: 1'b0};

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [16:0] accumulate(input logic [16:0] v, input logic [7:0] c);
        logic [19:0] wide;
        wide = ({3'b000, v} << 3) + ({3'b000, v} << 1) + {12'd0, c - CH_ZERO};
        return (wide > {3'b000, MAG_LIMIT}) ? MAG_LIMIT : wide[16:0];
    endfunction

    function automatic num_t num_feed(input num_t p, input logic [7:0] c);
        num_t r;
        r = p;
        case (p.phase)
            PH_SKIP:
            begin
                if (is_blank(c))
                begin
                    r = p;
                end
                else if ((c == CH_PLUS) || (c == CH_MINUS))
                begin
                    r.negative = (c == CH_MINUS);
                    r.phase    = PH_DIGITS;
                end
                else if (!is_digit(c))
                begin
                    r.phase = PH_DONE;
                end
                else
                begin
                    r.phase = PH_DIGITS;
                    r.value = accumulate(p.value, c);
                end
            end
            PH_DIGITS:
            begin
                if (!is_digit(c))
                begin
                    r.phase = PH_DONE;
                end
                else
                begin
                    r.value = accumulate(p.value, c);
                end
            end
            default:
            begin
                r = p;
            end
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] num_value(input num_t p);
        logic signed [17:0] m;
        m = $signed({1'b0, p.value});
        if (p.negative)
        begin
            return 16'(-m);
        end
        else if (p.value > 17'd32767)
        begin
            return 16'sh7FFF;
        end
        return 16'(m);
    endfunction

    function automatic logic signed [15:0] negate_sat(input logic signed [15:0] n);
        return (n == 16'sh8000) ? 16'sh7FFF : -n;
    endfunction

endpackage

@@ rtl/core/motor_command_line_parser_unit.sv @@
// Latency: a result for a recognised command appears in the cycle after its line-end item is accepted.
// Throughput: one item per cycle; a line end of a non-empty line waits only while
// the result register is full and stalled, all other items are taken regardless.
// Reset clears the line state, the kept speed and turn settings and the result valid.
// Line state, settings and result register for the motor command line parser.
// Depends on mclp_pkg.

module motor_command_line_parser_unit
    import mclp_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_stall,
    input  logic [7:0]         rx_byte,
    output logic               cmd_valid,
    input  logic               cmd_stall,
    output logic [1:0]         action,
    output logic signed [15:0] speed,
    output logic signed [15:0] turn,
    output logic signed [15:0] left_wheel,
    output logic signed [15:0] right_wheel
);

    localparam int LEN_W = (LINE_CAPACITY > 2) ? $clog2(LINE_CAPACITY) : 1;
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_CAPACITY - 1);

    logic [LEN_W-1:0]   len_reg, len_next;
    logic [7:0]         letter_reg, letter_next;
    logic               ended_reg, ended_next;
    num_t               first_reg, first_next;
    logic               y_seen_reg, y_seen_next;
    num_t               second_reg, second_next;
    logic signed [15:0] speed_set_reg, speed_set_next;
    logic signed [15:0] turn_set_reg, turn_set_next;

    logic               out_valid_reg, out_valid_next;
    action_t            action_reg, action_next;
    logic signed [15:0] speed_reg, speed_next;
    logic signed [15:0] turn_reg, turn_next;
    logic signed [15:0] left_reg, left_next;
    logic signed [15:0] right_reg, right_next;

    logic line_end;
    logic finish;
    logic accept;

    assign line_end = (rx_byte == CH_LF) || (rx_byte == CH_CR);
    assign finish   = line_end && (len_reg != '0);
    assign rx_stall = out_valid_reg && cmd_stall && finish;
    assign accept   = rx_valid && !rx_stall;

    always_comb
    begin
        logic [7:0]         op;
        logic signed [15:0] n;
        logic               hit;
        logic               now_ended;

        len_next       = len_reg;
        letter_next    = letter_reg;
        ended_next     = ended_reg;
        first_next     = first_reg;
        y_seen_next    = y_seen_reg;
        second_next    = second_reg;
        speed_set_next = speed_set_reg;
        turn_set_next  = turn_set_reg;

        out_valid_next = out_valid_reg && cmd_stall;
        action_next    = action_reg;
        speed_next     = speed_reg;
        turn_next      = turn_reg;
        left_next      = left_reg;
        right_next     = right_reg;

        op        = letter_reg;
        n         = num_value(first_reg);
        hit       = 1'b1;
        now_ended = ended_reg || (rx_byte == CH_NUL);

        if ((op >= CH_LC_A) && (op <= CH_LC_Z))
        begin
            op = op - 8'h20;
        end

        if (accept && finish)
        begin
            speed_next = '0;
            turn_next  = '0;
            left_next  = '0;
            right_next = '0;
            unique case (op)
                CH_F:
                begin
                    speed_set_next = n;
                    turn_set_next  = '0;
                    action_next    = ACT_DRIVE;
                end
                CH_B:
                begin
                    speed_set_next = negate_sat(n);
                    turn_set_next  = '0;
                    action_next    = ACT_DRIVE;
                end
                CH_L:
                begin
                    turn_set_next = n;
                    action_next   = ACT_DRIVE;
                end
                CH_R:
                begin
                    turn_set_next = negate_sat(n);
                    action_next   = ACT_DRIVE;
                end
                CH_S:
                begin
                    speed_set_next = '0;
                    turn_set_next  = '0;
                    action_next    = ACT_BRAKE;
                end
                CH_X:
                begin
                    left_next   = n;
                    right_next  = y_seen_reg ? num_value(second_reg) : n;
                    action_next = ACT_WHEELS;
                end
                default:
                begin
                    hit = 1'b0;
                end
            endcase
            if (hit && (action_next == ACT_DRIVE))
            begin
                speed_next = speed_set_next;
                turn_next  = turn_set_next;
            end
            out_valid_next = hit;

            len_next    = '0;
            letter_next = '0;
            ended_next  = 1'b0;
            first_next  = NUM_CLEAR;
            y_seen_next = 1'b0;
            second_next = NUM_CLEAR;
        end
        else if (accept && !line_end && (len_reg < LEN_LIMIT))
        begin
            ended_next = now_ended;
            if (!now_ended)
            begin
                if (len_reg == '0)
                begin
                    letter_next = rx_byte;
                end
                else
                begin
                    first_next = num_feed(first_reg, rx_byte);
                    if (y_seen_reg)
                    begin
                        second_next = num_feed(second_reg, rx_byte);
                    end
                    else if (rx_byte == CH_Y)
                    begin
                        y_seen_next = 1'b1;
                    end
                end
            end
            len_next = len_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            letter_reg    <= '0;
            ended_reg     <= 1'b0;
            first_reg     <= NUM_CLEAR;
            y_seen_reg    <= 1'b0;
            second_reg    <= NUM_CLEAR;
            speed_set_reg <= '0;
            turn_set_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            letter_reg    <= letter_next;
            ended_reg     <= ended_next;
            first_reg     <= first_next;
            y_seen_reg    <= y_seen_next;
            second_reg    <= second_next;
            speed_set_reg <= speed_set_next;
            turn_set_reg  <= turn_set_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        speed_reg  <= speed_next;
        turn_reg   <= turn_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
    end

    assign cmd_valid   = out_valid_reg;
    assign action      = action_reg;
    assign speed       = speed_reg;
    assign turn        = turn_reg;
    assign left_wheel  = left_reg;
    assign right_wheel = right_reg;

endmodule

@@ test/motor_command_line_parser_checker.sv @@
// Checker for the motor command line parser: watches both channels, predicts each command
// from the accepted text bytes and compares it with what the block delivers.
// Depends on mclp_pkg.
`timescale 1ns / 100ps

module motor_command_line_parser_checker
    import mclp_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    input  logic               rx_stall,
    input  logic [7:0]         rx_byte,
    input  logic               cmd_valid,
    input  logic               cmd_stall,
    input  logic [1:0]         action,
    input  logic signed [15:0] speed,
    input  logic signed [15:0] turn,
    input  logic signed [15:0] left_wheel,
    input  logic signed [15:0] right_wheel,
    output int                 failures,
    output int                 pending
);

    typedef struct packed {
        phase_t      phase;
        logic [16:0] mag;
        logic        neg;
    } number_scan_t;

    typedef struct packed {
        action_t            action;
        logic signed [15:0] speed;
        logic signed [15:0] turn;
        logic signed [15:0] left_wheel;
        logic signed [15:0] right_wheel;
    } command_t;

    int unsigned        kept_len;
    logic [7:0]         letter;
    logic               text_done;
    number_scan_t       arg_a;
    number_scan_t       arg_b;
    logic               y_seen;
    logic signed [15:0] speed_kept;
    logic signed [15:0] turn_kept;
    command_t           expected_cmds[$];

    function automatic logic blank_char(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    endfunction

    function automatic logic signed [15:0] sat16(input int v);
        if (v > 32767)
        begin
            return 16'sh7FFF;
        end
        else if (v < -32768)
        begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    function automatic logic signed [15:0] scan_value(input number_scan_t s);
        int m;
        m = int'(s.mag);
        return sat16(s.neg ? -m : m);
    endfunction

    function automatic number_scan_t scan_char(input number_scan_t s, input logic [7:0] c);
        logic        digit;
        int unsigned acc;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if ((s.phase != PH_SKIP) && (s.phase != PH_DIGITS))
        begin
            return s;
        end
        if ((s.phase == PH_SKIP) && blank_char(c))
        begin
            return s;
        end
        if ((s.phase == PH_SKIP) && ((c == CH_PLUS) || (c == CH_MINUS)))
        begin
            s.neg   = (c == CH_MINUS);
            s.phase = PH_DIGITS;
            return s;
        end
        if (!digit)
        begin
            s.phase = PH_DONE;
            return s;
        end
        s.phase = PH_DIGITS;
        acc = 32'(s.mag);
        acc = acc * 10 + 32'(c - CH_ZERO);
        s.mag = (acc > 32768) ? 17'd32768 : acc[16:0];
        return s;
    endfunction

    task automatic clear_line();
        kept_len  = 0;
        letter    = '0;
        text_done = 1'b0;
        arg_a     = '{phase: PH_SKIP, mag: 17'd0, neg: 1'b0};
        arg_b     = '{phase: PH_SKIP, mag: 17'd0, neg: 1'b0};
        y_seen    = 1'b0;
    endtask

    initial
    begin
        failures = 0;
        pending  = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        command_t           got;
        command_t           fresh;
        logic [7:0]         c;
        logic [7:0]         op;
        logic signed [15:0] n;
        logic               recognised;
        if (!rst_n)
        begin
            clear_line();
            speed_kept = '0;
            turn_kept  = '0;
            expected_cmds.delete();
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                if (expected_cmds.size() == 0)
                begin
                    $error("command with none expected: action %0d speed %0d turn %0d",
                           action, speed, turn);
                    failures++;
                end
                else
                begin
                    got = expected_cmds.pop_front();
                    if (action !== got.action)
                    begin
                        $error("action: expected %0d, got %0d", got.action, action);
                        failures++;
                    end
                    if (speed !== got.speed)
                    begin
                        $error("speed: expected %0d, got %0d", got.speed, speed);
                        failures++;
                    end
                    if (turn !== got.turn)
                    begin
                        $error("turn: expected %0d, got %0d", got.turn, turn);
                        failures++;
                    end
                    if (left_wheel !== got.left_wheel)
                    begin
                        $error("left_wheel: expected %0d, got %0d", got.left_wheel, left_wheel);
                        failures++;
                    end
                    if (right_wheel !== got.right_wheel)
                    begin
                        $error("right_wheel: expected %0d, got %0d",
                               got.right_wheel, right_wheel);
                        failures++;
                    end
                end
            end
            if (rx_valid && !rx_stall)
            begin
                c = rx_byte;
                if ((c == CH_LF) || (c == CH_CR))
                begin
                    if (kept_len > 0)
                    begin
                        op = letter;
                        if ((op >= CH_LC_A) && (op <= CH_LC_Z))
                        begin
                            op = op - 8'h20;
                        end
                        n          = scan_value(arg_a);
                        fresh      = '0;
                        fresh.action = ACT_DRIVE;
                        recognised = 1'b1;
                        case (op)
                            CH_F:
                            begin
                                speed_kept = n;
                                turn_kept  = '0;
                            end
                            CH_B:
                            begin
                                speed_kept = sat16(-int'(n));
                                turn_kept  = '0;
                            end
                            CH_L:
                            begin
                                turn_kept = n;
                            end
                            CH_R:
                            begin
                                turn_kept = sat16(-int'(n));
                            end
                            CH_S:
                            begin
                                speed_kept   = '0;
                                turn_kept    = '0;
                                fresh.action = ACT_BRAKE;
                            end
                            CH_X:
                            begin
                                fresh.action      = ACT_WHEELS;
                                fresh.left_wheel  = n;
                                fresh.right_wheel = y_seen ? scan_value(arg_b) : n;
                            end
                            default:
                            begin
                                recognised = 1'b0;
                            end
                        endcase
                        if (fresh.action == ACT_DRIVE)
                        begin
                            fresh.speed = speed_kept;
                            fresh.turn  = turn_kept;
                        end
                        if (recognised)
                        begin
                            expected_cmds.push_back(fresh);
                        end
                        clear_line();
                    end
                end
                else if (kept_len < LINE_CAPACITY - 1)
                begin
                    if (c == CH_NUL)
                    begin
                        text_done = 1'b1;
                    end
                    if (!text_done)
                    begin
                        if (kept_len == 0)
                        begin
                            letter = c;
                        end
                        else
                        begin
                            arg_a = scan_char(arg_a, c);
                            if (y_seen)
                            begin
                                arg_b = scan_char(arg_b, c);
                            end
                            else if (c == CH_Y)
                            begin
                                y_seen = 1'b1;
                            end
                        end
                    end
                    kept_len++;
                end
            end
        end
        pending = expected_cmds.size();
    end

endmodule

@@ test/tb_motor_command_line_parser_unit.sv @@
// Top of the motor command line parser bench: clock, reset, text stimulus and receiver stalls.
// Instantiates motor_command_line_parser_unit and motor_command_line_parser_checker.
// Depends on mclp_pkg.
`timescale 1ns / 100ps

module tb_motor_command_line_parser_unit;
    import mclp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 340;

    logic               clk;
    logic               rst_n;
    logic               rx_valid;
    logic               rx_stall;
    logic [7:0]         rx_byte;
    logic               cmd_valid;
    logic               cmd_stall;
    logic [1:0]         action;
    logic signed [15:0] speed;
    logic signed [15:0] turn;
    logic signed [15:0] left_wheel;
    logic signed [15:0] right_wheel;

    int failure_count;
    int pending_cmds;
    int bytes_sent;
    int gap_pct;
    int stall_pct;
    int hold_left;
    int cycle_count;

    motor_command_line_parser_unit DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .rx_byte     (rx_byte),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .action      (action),
        .speed       (speed),
        .turn        (turn),
        .left_wheel  (left_wheel),
        .right_wheel (right_wheel)
    );

    motor_command_line_parser_checker result_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .rx_byte     (rx_byte),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .action      (action),
        .speed       (speed),
        .turn        (turn),
        .left_wheel  (left_wheel),
        .right_wheel (right_wheel),
        .failures    (failure_count),
        .pending     (pending_cmds)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        cmd_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                cmd_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                cmd_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            rx_valid <= 1'b0;
            @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall)
        begin
            @(posedge clk);
        end
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_byte(s[i]);
        end
    endtask

    function automatic logic [7:0] any_blank();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    task automatic push_number();
        repeat ($urandom_range(0, 2))
        begin
            push_byte(any_blank());
        end
        case ($urandom_range(0, 3))
            0: push_byte(CH_MINUS);
            1: push_byte(CH_PLUS);
            default: ;
        endcase
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 4))
                0: push_text("32767");
                1: push_text("32768");
                2: push_text("32769");
                3: push_text("999999");
                default: push_text("0");
            endcase
        end
        else
        begin
            repeat ($urandom_range(0, 5))
            begin
                push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end
    endtask

    task automatic emit_line();
        int         kind;
        logic [7:0] op;
        logic [7:0] folded;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            case ($urandom_range(0, 5))
                0: op = CH_F;
                1: op = CH_B;
                2: op = CH_L;
                3: op = CH_R;
                4: op = CH_S;
                default: op = CH_X;
            endcase
            if ($urandom_range(0, 3) == 0)
            begin
                op = op | 8'h20;
            end
            push_byte(op);
            push_number();
            if (((op & 8'hDF) == CH_X) && ($urandom_range(0, 3) != 0))
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    push_byte(any_blank());
                end
                push_byte(($urandom_range(0, 4) == 0) ? (CH_Y | 8'h20) : CH_Y);
                push_number();
            end
            if ($urandom_range(0, 9) == 0)
            begin
                push_byte(CH_NUL);
                push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end
        else if (kind < 85)
        begin
            repeat ($urandom_range(0, 12))
            begin
                push_byte(8'($urandom_range(0, 255)));
            end
        end
        else if (kind < 95)
        begin
            do
            begin
                op     = 8'($urandom_range(0, 255));
                folded = ((op >= CH_LC_A) && (op <= CH_LC_Z)) ? op - 8'h20 : op;
            end
            while ((op == CH_LF) || (op == CH_CR) || (folded == CH_F) || (folded == CH_B)
                   || (folded == CH_L) || (folded == CH_R) || (folded == CH_S)
                   || (folded == CH_X));
            push_byte(op);
            push_number();
        end
        else
        begin
            push_byte(($urandom_range(0, 1) == 0) ? CH_F : CH_X);
            repeat ($urandom_range(55, 66))
            begin
                push_byte(any_blank());
            end
            repeat ($urandom_range(1, 5))
            begin
                push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end
        push_byte(($urandom_range(0, 1) == 0) ? CH_LF : CH_CR);
        if ($urandom_range(0, 5) == 0)
        begin
            push_byte(CH_LF);
        end
    endtask

    initial
    begin
        int target;
        rst_n      = 1'b0;
        rx_valid   = 1'b0;
        rx_byte    = '0;
        bytes_sent = 0;
        gap_pct    = 0;
        stall_pct  = 0;
        hold_left  = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_text("F-32768\n");
        push_text("B-32768\r");
        push_text("l99999\n");
        push_text("R+7\n");
        push_text("S\n");
        push_text("X 12Y-3\n");
        push_text("x5y9\n");
        push_text("\nQ1\n");
        push_byte(CH_NUL);
        push_text("F1\n");
        push_text("F1");
        push_byte(CH_NUL);
        push_text("2\nL");
        push_byte(CH_VT);
        push_byte(CH_FF);
        push_text("\t 9\nF");
        push_byte(8'hFF);
        push_byte(CH_CR);

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                    hold_left = HOLD_CYCLES;
                end
                1:
                begin
                    gap_pct   = 52;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 52;
                end
                3:
                begin
                    gap_pct   = 30;
                    stall_pct = 30;
                end
                default:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
            endcase
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target)
            begin
                emit_line();
            end
        end

        rx_valid  <= 1'b0;
        stall_pct = 0;
        while (pending_cmds != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (failure_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
